/* design/psre_pkg.sv */
// Shared types, constants and arithmetic helpers for the pen report encoder.
package psre_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN = 24;
    localparam int REPORT_LEN = 27;
    localparam int IDX_W = 5;
    localparam int STEP_W = 5;
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    localparam logic [2:0] EV_HOVER = 3'd0;
    localparam logic [2:0] EV_DOWN = 3'd1;
    localparam logic [2:0] EV_UP = 3'd2;
    localparam logic [2:0] EV_MOVE = 3'd3;
    localparam logic [2:0] EV_CANCEL = 3'd4;
    localparam logic [2:0] EV_BUTTONS = 3'd5;
    localparam logic [2:0] EV_LEAVE = 3'd6;
    localparam logic [2:0] EV_CANCEL_ALL = 3'd7;

    localparam logic [1:0] TOOL_PEN = 2'd1;
    localparam logic [1:0] TOOL_ERASER = 2'd2;
    localparam logic [1:0] FMT_NATIVE = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  tool;
        logic [7:0]  buttons;
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] pod;
        logic [6:0]  tilt;
        logic        tilt_unk;
        logic [8:0]  rot;
        logic        rot_unk;
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROT_T, ST_ROT_R, ST_MUL_X, ST_MUL_Y, ST_VEC_X, ST_VEC_Y,
        ST_SCALE, ST_EMIT
    } back_state_t;

    function automatic logic signed [31:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd2949120;  5'd1: v = 32'sd1740967;
            5'd2: v = 32'sd919879;   5'd3: v = 32'sd466945;
            5'd4: v = 32'sd234379;   5'd5: v = 32'sd117304;
            5'd6: v = 32'sd58666;    5'd7: v = 32'sd29335;
            5'd8: v = 32'sd14668;    5'd9: v = 32'sd7334;
            5'd10: v = 32'sd3667;    5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;     5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;     5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;      5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;      5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;       5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q16 clamp of a signed position to 0..1.0
    function automatic logic [16:0] clamp_pos(input logic signed [17:0] v);
        logic [16:0] r;
        if (v < 0) r = 17'd0;
        else if (v > 18'sd65536) r = Q16_ONE;
        else r = v[16:0];
        return r;
    endfunction

endpackage

/* design/psre_front.sv */
// Front end: accept and clamp pen events into a two-entry queue.
module psre_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  ready,
    input  logic [2:0]            event_kind,
    input  logic [1:0]            tool_kind,
    input  logic [7:0]            button_bits,
    input  logic signed [17:0]    pos_x,
    input  logic signed [17:0]    pos_y,
    input  logic [16:0]           pressure_or_distance,
    input  logic [6:0]            tilt_deg,
    input  logic                  tilt_unknown,
    input  logic [8:0]            rotation_deg,
    input  logic                  rotation_unknown,
    output logic                  q_valid,
    output psre_pkg::event_t      q_event,
    input  logic                  q_pop
);
    psre_pkg::event_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_reg, wr_reg;
    psre_pkg::event_t ev;
    logic push;

    always_comb
    begin
        ev.kind = event_kind;
        ev.tool = tool_kind;
        ev.buttons = button_bits;
        ev.x = psre_pkg::clamp_pos(pos_x);
        ev.y = psre_pkg::clamp_pos(pos_y);
        ev.pod = (pressure_or_distance > psre_pkg::Q16_ONE) ? psre_pkg::Q16_ONE
                                                          : pressure_or_distance;
        ev.tilt = tilt_deg;
        ev.tilt_unk = tilt_unknown;
        ev.rot = rotation_deg;
        ev.rot_unk = rotation_unknown;
    end

    assign ready = (count_reg != 2'd2);
    assign push = valid && ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_event = slot_reg[rd_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_pop) rd_reg <= ~rd_reg;
            if (push) wr_reg <= ~wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_reg] <= ev;
    end
endmodule

/* design/psre_back.sv */
// Back end: pen state update, CORDIC tilt conversion and report serializer.
module psre_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         fmt,
    input  logic               q_valid,
    input  psre_pkg::event_t   q_event,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last
);
    psre_pkg::back_state_t state_reg, state_next;
    psre_pkg::event_t ev_reg;

    logic        in_range_reg, tip_reg, eraser_reg;
    logic [7:0]  btn_reg;
    logic [16:0] x_reg, y_reg, pres_reg, dist_reg;
    logic signed [7:0] tx_reg, ty_reg;

    // tilts before this event, restored when the event does not set them
    logic signed [7:0] tx_reg_keep, ty_reg_keep;

    // CORDIC datapath
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               flip_reg;
    logic signed [31:0] base_reg;
    logic [4:0]         step_reg;
    logic signed [31:0] ct_reg, st_reg, cr_reg, sr_reg;
    logic signed [63:0] prod_reg;
    logic signed [33:0] yx_reg, yy_reg;

    // report fields
    logic [16:0] sx_reg, sy_reg, sp_reg;
    logic [5:0]  sd_reg;
    logic [4:0]  idx_reg;
    logic        native_reg;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_c;

    logic signed [33:0] dx, dy;
    logic signed [31:0] zang;
    logic               rot_dir;
    logic signed [33:0] nx, ny;
    logic signed [31:0] nz;
    logic               last_step;

    function automatic logic signed [33:0] asr34(input logic signed [33:0] v,
                                                 input logic [4:0] s);
        return v >>> s;
    endfunction

    // Reduce an angle mod 360 and fold into -90..90.
    function automatic logic signed [9:0] fold(input logic [8:0] a,
                                               output logic fl);
        logic signed [10:0] b;
        b = (a >= 9'd360) ? $signed({2'b0, a - 9'd360}) : $signed({2'b0, a});
        fl = 1'b0;
        if (b > 11'sd180) b = b - 11'sd360;
        if (b > 11'sd90)
        begin
            b = b - 11'sd180;
            fl = 1'b1;
        end
        else if (b < -11'sd90)
        begin
            b = b + 11'sd180;
            fl = 1'b1;
        end
        return b[9:0];
    endfunction

    function automatic logic signed [7:0] round_deg(input logic signed [31:0] v);
        logic signed [31:0] m, r;
        m = (v < 0) ? -v : v;
        r = (m + 32'sd32768) >>> 16;
        if (v < 0) r = -r;
        if (r > 32'sd90) r = 32'sd90;
        if (r < -32'sd90) r = -32'sd90;
        return r[7:0];
    endfunction

    // Q30 product truncated toward zero
    function automatic logic signed [33:0] q30(input logic signed [63:0] p);
        logic signed [63:0] m;
        m = (p < 0) ? -p : p;
        m = m >>> 30;
        if (p < 0) m = -m;
        return m[33:0];
    endfunction

    function automatic logic [16:0] scl(input logic [16:0] v, input logic [16:0] mx);
        logic [33:0] p;
        p = v * mx;
        return p[32:16];
    endfunction

    function automatic logic signed [7:0] clamp64(input logic signed [7:0] v);
        logic signed [7:0] r;
        r = v;
        if (v > 8'sd63) r = 8'sd63;
        if (v < -8'sd64) r = -8'sd64;
        return r;
    endfunction

    // one shared CORDIC micro-step; vectoring drives y toward zero
    always_comb
    begin
        dx = asr34(cy_reg, step_reg);
        dy = asr34(cx_reg, step_reg);
        zang = psre_pkg::atan_q16(step_reg);
        if (state_reg == psre_pkg::ST_VEC_X || state_reg == psre_pkg::ST_VEC_Y)
            rot_dir = (cy_reg < 34'sd0);
        else
            rot_dir = (cz_reg >= 32'sd0);
        if (rot_dir)
        begin
            nx = cx_reg - dx;
            ny = cy_reg + dy;
            nz = cz_reg - zang;
        end
        else
        begin
            nx = cx_reg + dx;
            ny = cy_reg - dy;
            nz = cz_reg + zang;
        end
        last_step = (step_reg == 5'(psre_pkg::CORDIC_STEPS - 1));
    end

    logic tilt_path;
    assign tilt_path = !ev_reg.tilt_unk && !ev_reg.rot_unk;

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        case (state_reg)
            psre_pkg::ST_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = psre_pkg::ST_ROT_T;
                end
            psre_pkg::ST_ROT_T: if (last_step) state_next = psre_pkg::ST_ROT_R;
            psre_pkg::ST_ROT_R: if (last_step) state_next = psre_pkg::ST_MUL_X;
            psre_pkg::ST_MUL_X: state_next = psre_pkg::ST_MUL_Y;
            psre_pkg::ST_MUL_Y: state_next = psre_pkg::ST_VEC_X;
            psre_pkg::ST_VEC_X: if (last_step) state_next = psre_pkg::ST_VEC_Y;
            psre_pkg::ST_VEC_Y: if (last_step) state_next = psre_pkg::ST_SCALE;
            psre_pkg::ST_SCALE: state_next = psre_pkg::ST_EMIT;
            psre_pkg::ST_EMIT:
                if (out_ready && idx_reg == 5'(psre_pkg::REPORT_LEN - 1))
                    state_next = psre_pkg::ST_IDLE;
            default: state_next = psre_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= psre_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // Start a vectoring pass: negative x starts from +-180 degrees.
    task automatic start_vec(input logic signed [33:0] x, input logic signed [33:0] y);
        step_reg <= 5'd0;
        cz_reg <= 32'sd0;
        if (x < 0)
        begin
            base_reg <= (y >= 0) ? 32'sd11796480 : -32'sd11796480;
            cx_reg <= -x;
            cy_reg <= -y;
        end
        else
        begin
            base_reg <= 32'sd0;
            cx_reg <= x;
            cy_reg <= y;
        end
    endtask

    task automatic start_rot(input logic [8:0] a);
        logic fl;
        logic signed [9:0] f;
        f = fold(a, fl);
        flip_reg <= fl;
        cz_reg <= 32'(f) <<< 16;
        cx_reg <= 34'(psre_pkg::INV_GAIN_Q30);
        cy_reg <= 34'sd0;
        step_reg <= 5'd0;
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
            tip_reg <= 1'b0;
            eraser_reg <= 1'b0;
            btn_reg <= 8'd0;
            x_reg <= 17'd32768;
            y_reg <= 17'd32768;
            pres_reg <= 17'd0;
            dist_reg <= psre_pkg::Q16_ONE;
            tx_reg <= 8'sd0;
            ty_reg <= 8'sd0;
            idx_reg <= 5'd0;
        end
        else
        begin
            case (state_reg)
                psre_pkg::ST_IDLE:
                    if (q_valid)
                    begin
                        ev_reg <= q_event;
                        idx_reg <= 5'd0;
                        start_rot({2'b0, q_event.tilt});
                    end
                psre_pkg::ST_ROT_T:
                    if (last_step)
                    begin
                        ct_reg <= flip_reg ? -nx[31:0] : nx[31:0];
                        st_reg <= flip_reg ? -ny[31:0] : ny[31:0];
                        start_rot(ev_reg.rot);
                    end
                    else
                    begin
                        cx_reg <= nx; cy_reg <= ny; cz_reg <= nz;
                        step_reg <= step_reg + 5'd1;
                    end
                psre_pkg::ST_ROT_R:
                begin
                    cx_reg <= nx; cy_reg <= ny; cz_reg <= nz;
                    step_reg <= step_reg + 5'd1;
                    if (last_step)
                    begin
                        cr_reg <= flip_reg ? -nx[31:0] : nx[31:0];
                        sr_reg <= flip_reg ? -ny[31:0] : ny[31:0];
                    end
                end
                psre_pkg::ST_MUL_X:
                    prod_reg <= sr_reg * st_reg;
                psre_pkg::ST_MUL_Y:
                begin
                    yx_reg <= -q30(prod_reg);
                    prod_reg <= cr_reg * st_reg;
                    start_vec(34'(ct_reg), -q30(prod_reg));
                end
                psre_pkg::ST_VEC_X:
                    if (last_step)
                    begin
                        if (ct_reg == 0 && yx_reg == 0) tx_reg <= 8'sd0;
                        else tx_reg <= round_deg(base_reg + nz);
                        yy_reg <= q30(prod_reg);
                        start_vec(34'(ct_reg), q30(prod_reg));
                    end
                    else
                    begin
                        cx_reg <= nx; cy_reg <= ny; cz_reg <= nz;
                        step_reg <= step_reg + 5'd1;
                    end
                psre_pkg::ST_VEC_Y:
                begin
                    cx_reg <= nx; cy_reg <= ny; cz_reg <= nz;
                    step_reg <= step_reg + 5'd1;
                    if (last_step)
                    begin
                        if (ct_reg == 0 && yy_reg == 0) ty_reg <= 8'sd0;
                        else ty_reg <= round_deg(base_reg + nz);
                    end
                end
                psre_pkg::ST_SCALE:
                begin
                    // apply the event to the kept state
                    if (ev_reg.tool == psre_pkg::TOOL_PEN) eraser_reg <= 1'b0;
                    else if (ev_reg.tool == psre_pkg::TOOL_ERASER) eraser_reg <= 1'b1;
                    if (ev_reg.kind == psre_pkg::EV_BUTTONS)
                    begin
                        btn_reg <= ev_reg.buttons;
                        tx_reg <= tx_reg_keep;
                        ty_reg <= ty_reg_keep;
                    end
                    else if (ev_reg.kind == psre_pkg::EV_CANCEL ||
                             ev_reg.kind == psre_pkg::EV_LEAVE ||
                             ev_reg.kind == psre_pkg::EV_CANCEL_ALL)
                    begin
                        in_range_reg <= 1'b0;
                        tip_reg <= 1'b0;
                        pres_reg <= 17'd0;
                        btn_reg <= 8'd0;
                        tx_reg <= tx_reg_keep;
                        ty_reg <= ty_reg_keep;
                    end
                    else
                    begin
                        in_range_reg <= 1'b1;
                        x_reg <= ev_reg.x;
                        y_reg <= ev_reg.y;
                        btn_reg <= ev_reg.buttons;
                        if (ev_reg.kind == psre_pkg::EV_DOWN ||
                            (ev_reg.kind == psre_pkg::EV_MOVE && tip_reg))
                        begin
                            if (ev_reg.pod != 17'd0) pres_reg <= ev_reg.pod;
                            else if (ev_reg.kind == psre_pkg::EV_DOWN)
                                pres_reg <= 17'd655;
                            tip_reg <= 1'b1;
                            dist_reg <= 17'd0;
                        end
                        else if (ev_reg.kind == psre_pkg::EV_UP)
                        begin
                            tip_reg <= 1'b0;
                            pres_reg <= 17'd0;
                            dist_reg <= 17'd3277;
                        end
                        else
                        begin
                            tip_reg <= 1'b0;
                            pres_reg <= 17'd0;
                            dist_reg <= (ev_reg.pod != 17'd0) ? ev_reg.pod : 17'd19661;
                        end
                        if (ev_reg.tilt_unk)
                        begin
                            tx_reg <= 8'sd0;
                            ty_reg <= 8'sd0;
                        end
                        else if (!tilt_path)
                        begin
                            tx_reg <= tx_reg_keep;
                            ty_reg <= ty_reg_keep;
                        end
                    end
                end
                psre_pkg::ST_EMIT:
                    if (out_ready) idx_reg <= idx_reg + 5'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg_keep <= 8'sd0;
            ty_reg_keep <= 8'sd0;
        end
        else if (state_reg == psre_pkg::ST_EMIT)
        begin
            tx_reg_keep <= tx_reg;
            ty_reg_keep <= ty_reg;
        end
    end

    // scaled report fields, computed from the updated state
    logic native;
    assign native = (fmt == psre_pkg::FMT_NATIVE);

    always_ff @(posedge clk)
    begin
        if (state_reg == psre_pkg::ST_EMIT && idx_reg == 5'd0)
        begin
            native_reg <= native;
            sx_reg <= native ? 17'd0 : scl(x_reg, 17'd32767);
            sy_reg <= native ? 17'd0 : scl(y_reg, 17'd32767);
            sp_reg <= !tip_reg ? 17'd0 :
                      native ? scl(pres_reg, 17'd8191) : scl(pres_reg, 17'd2047);
            sd_reg <= tip_reg ? 6'd0 :
                      in_range_reg ? 6'(scl(dist_reg, 17'd63)) : 6'd63;
            flags_reg <= flags_c;
        end
    end

    always_comb
    begin
        flags_c = native ? 8'h40 : 8'h00;
        if (in_range_reg)
        begin
            flags_c[5] = 1'b1;
            if (eraser_reg)
            begin
                flags_c[4] = 1'b1;
                flags_c[3] = tip_reg;
            end
            else flags_c[0] = tip_reg;
            flags_c[1] = btn_reg[0];
            flags_c[2] = btn_reg[1];
        end
    end

    logic [23:0] nx24, ny24;
    assign nx24 = 24'((x_reg * 34'd96012) >> 16);
    assign ny24 = 24'((y_reg * 34'd54358) >> 16);

    // Byte 0, native x/y, tilts, tail: state, combinational; others: captured fields.
    logic [7:0] b;
    logic [7:0] flg, txb, tyb, ser;
    logic [16:0] px, py, pp;
    logic [5:0]  pd;
    logic        nat;
    logic [79:0] serial;
    always_comb
    begin
        nat = (idx_reg == 5'd0) ? native : native_reg;
        flg = (idx_reg == 5'd0) ? flags_c : flags_reg;
        px = sx_reg; py = sy_reg; pp = sp_reg; pd = sd_reg;
        txb = nat ? clamp64(tx_reg) : tx_reg;
        tyb = nat ? clamp64(ty_reg) : ty_reg;
        serial = in_range_reg ?
                 {eraser_reg ? 16'h084A : 16'h0842, 32'h00100842, 32'h97800A01} : 80'd0;
        ser = 8'(serial >> (8 * (idx_reg - 5'd17)));
        b = 8'd0;
        case (idx_reg)
            5'd0: b = nat ? 8'h10 : 8'h06;
            5'd1: b = flg;
            5'd2: b = nat ? nx24[7:0] : px[7:0];
            5'd3: b = nat ? nx24[15:8] : px[15:8];
            5'd4: b = nat ? nx24[23:16] : 8'd0;
            5'd5: b = nat ? ny24[7:0] : py[7:0];
            5'd6: b = nat ? ny24[15:8] : py[15:8];
            5'd7: b = nat ? ny24[23:16] : 8'd0;
            5'd8: b = pp[7:0];
            5'd9: b = pp[15:8];
            5'd10: b = txb;
            5'd11: b = tyb;
            5'd16: b = {2'b0, pd};
            default: b = (idx_reg >= 5'd17) ? ser : 8'd0;
        endcase
    end

    assign out_valid = (state_reg == psre_pkg::ST_EMIT);
    assign out_byte = b;
    assign out_last = (idx_reg == 5'(psre_pkg::REPORT_LEN - 1));
endmodule

/* design/pen_state_report_encoder_unit.sv */
// Pen state report encoder: front queue, back state/CORDIC/serializer.
// Before the first report byte: two 16-step CORDIC rotations (tilt, rotation),
//   two multiplies, two 16-step vectoring passes and one update state.
// A report is 27 bytes, sent one per cycle while out_ready is high.
// One event is in the back end at a time; a two-entry queue takes new events meanwhile.
// Reset (rst_n, async low): pen state to its idle values, format to generic.
module pen_state_report_encoder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        event_kind,
    input  logic [1:0]        tool_kind,
    input  logic [7:0]        button_bits,
    input  logic signed [17:0] pos_x,
    input  logic signed [17:0] pos_y,
    input  logic [16:0]       pressure_or_distance,
    input  logic [6:0]        tilt_deg,
    input  logic              tilt_unknown,
    input  logic [8:0]        rotation_deg,
    input  logic              rotation_unknown,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        report_byte,
    output logic              last_byte
);
    logic [1:0] fmt_reg;
    logic q_valid, q_pop;
    psre_pkg::event_t q_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fmt_reg <= 2'd1;
        else if (cfg_we) fmt_reg <= cfg_wdata;
    end

    psre_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .event_kind(event_kind), .tool_kind(tool_kind), .button_bits(button_bits),
        .pos_x(pos_x), .pos_y(pos_y), .pressure_or_distance(pressure_or_distance),
        .tilt_deg(tilt_deg), .tilt_unknown(tilt_unknown), .rotation_deg(rotation_deg),
        .rotation_unknown(rotation_unknown), .q_valid(q_valid), .q_event(q_event),
        .q_pop(q_pop)
    );

    psre_back u_back (
        .clk(clk), .rst_n(rst_n), .fmt(fmt_reg), .q_valid(q_valid), .q_event(q_event),
        .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(report_byte), .out_last(last_byte)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> !out_valid)
        else $error("report continues past last byte");
endmodule

/* bench/testbench.sv */
// Self-checking bench for the pen state report encoder: directed table, then random pen strokes.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [1:0]  fmt;
        logic [2:0]  kind;
        logic [1:0]  tool;
        logic [7:0]  buttons;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [16:0] pod;
        logic [6:0]  tilt;
        logic        tilt_unk;
        logic [8:0]  rot;
        logic        rot_unk;
        bit          typed;
        logic [7:0]  id_byte;
        logic [7:0]  flag_byte;
    } pen_row_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
    } report_word_t;

    typedef struct {
        bit         typed;
        logic [7:0] id_byte;
        logic [7:0] flag_byte;
    } typed_head_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] event_kind = '0;
    logic [1:0] tool_kind = '0;
    logic [7:0] button_bits = '0;
    logic signed [17:0] pos_x = '0;
    logic signed [17:0] pos_y = '0;
    logic [16:0] pressure_or_distance = '0;
    logic [6:0] tilt_deg = '0;
    logic tilt_unknown = 1'b0;
    logic [8:0] rotation_deg = '0;
    logic rotation_unknown = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] report_byte;
    logic last_byte;

    pen_state_report_encoder_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .event_kind(event_kind),
        .tool_kind(tool_kind), .button_bits(button_bits), .pos_x(pos_x), .pos_y(pos_y),
        .pressure_or_distance(pressure_or_distance), .tilt_deg(tilt_deg),
        .tilt_unknown(tilt_unknown), .rotation_deg(rotation_deg),
        .rotation_unknown(rotation_unknown), .out_valid(out_valid), .out_ready(out_ready),
        .report_byte(report_byte), .last_byte(last_byte)
    );

    always #5 clk = ~clk;

    // pen state mirror
    logic [1:0] fmt_m = 2'd1;
    bit in_range_m, tip_m, eraser_m;
    logic [7:0] buttons_m;
    int unsigned x_m, y_m, pres_m, dist_m;
    int tilt_x_m, tilt_y_m;

    report_word_t report_q[$];
    typed_head_t typed_q[$];
    int errors = 0;
    int events_sent = 0;
    int words_checked = 0;
    int idle_cycles = 0;

    const longint ATAN_DEG[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic void sin_cos_q30(input int unsigned deg, output longint c,
                                        output longint s);
        int a;
        bit flip;
        longint x, y, z, dx, dy;
        a = int'(deg % 360);
        flip = 0;
        if (a > 180) a -= 360;
        if (a > 90)
        begin
            a -= 180;
            flip = 1;
        end
        else if (a < -90)
        begin
            a += 180;
            flip = 1;
        end
        z = longint'(a) * 65536;
        x = 652032874;
        y = 0;
        for (int i = 0; i < psre_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_DEG[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_DEG[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint angle_q16(input longint x0, input longint y0);
        longint x, y, z, base, dx, dy;
        x = x0;
        y = y0;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < psre_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x -= dx; y += dy; z -= ATAN_DEG[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_DEG[i];
            end
        end
        return base + z;
    endfunction

    function automatic int whole_deg(input longint v);
        longint r;
        r = (v >= 0) ? ((v + 32768) >>> 16) : -((-v + 32768) >>> 16);
        if (r < -90) r = -90;
        if (r > 90) r = 90;
        return int'(r);
    endfunction

    function automatic int unsigned clamp_unit(input longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return int'(v);
    endfunction

    function automatic int clamp_tilt(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned scaled(input int unsigned q, input int unsigned mx);
        return int'((longint'(q) * mx) >> 16);
    endfunction

    function automatic void push_le(input int unsigned v, input int n);
        report_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.b = v[8*i +: 8];
            w.l = 1'b0;
            report_q.insert(report_q.size(), w);
        end
    endfunction

    // advance the mirrored pen state by one event and queue its report
    function automatic void predict_report();
        int unsigned pod;
        longint ct, st, cr, sr, yx, yy;
        bit native;
        int unsigned flags, dist_code, pres;
        int tx, ty;
        pod = clamp_unit(longint'(pressure_or_distance));
        if (tool_kind == psre_pkg::TOOL_PEN) eraser_m = 0;
        else if (tool_kind == psre_pkg::TOOL_ERASER) eraser_m = 1;
        if (event_kind == psre_pkg::EV_BUTTONS)
            buttons_m = button_bits;
        else if (event_kind == psre_pkg::EV_CANCEL || event_kind == psre_pkg::EV_LEAVE ||
                 event_kind == psre_pkg::EV_CANCEL_ALL)
        begin
            in_range_m = 0; tip_m = 0; pres_m = 0; buttons_m = 0;
        end
        else
        begin
            in_range_m = 1;
            x_m = clamp_unit(longint'(pos_x));
            y_m = clamp_unit(longint'(pos_y));
            buttons_m = button_bits;
            if (event_kind == psre_pkg::EV_DOWN ||
                (event_kind == psre_pkg::EV_MOVE && tip_m))
            begin
                if (pod > 0) pres_m = pod;
                else if (event_kind == psre_pkg::EV_DOWN) pres_m = 655;
                tip_m = 1;
                dist_m = 0;
            end
            else if (event_kind == psre_pkg::EV_UP)
            begin
                tip_m = 0; pres_m = 0; dist_m = 3277;
            end
            else
            begin
                tip_m = 0; pres_m = 0;
                dist_m = (pod > 0) ? pod : 19661;
            end
            if (!tilt_unknown && !rotation_unknown)
            begin
                sin_cos_q30(tilt_deg, ct, st);
                sin_cos_q30(rotation_deg, cr, sr);
                yx = -((sr * st) / 64'sd1073741824);
                yy = (cr * st) / 64'sd1073741824;
                tilt_x_m = whole_deg(angle_q16(ct, yx));
                tilt_y_m = whole_deg(angle_q16(ct, yy));
            end
            else if (tilt_unknown)
            begin
                tilt_x_m = 0; tilt_y_m = 0;
            end
        end

        native = (fmt_m == psre_pkg::FMT_NATIVE);
        flags = native ? 'h40 : 0;
        if (in_range_m)
        begin
            flags |= 'h20;
            if (eraser_m)
            begin
                flags |= 'h10;
                if (tip_m) flags |= 'h08;
            end
            else if (tip_m) flags |= 'h01;
            if (buttons_m[0]) flags |= 'h02;
            if (buttons_m[1]) flags |= 'h04;
        end
        dist_code = tip_m ? 0 : (in_range_m ? scaled(dist_m, 63) : 63);
        if (native)
        begin
            pres = tip_m ? scaled(pres_m, 8191) : 0;
            tx = clamp_tilt(tilt_x_m, -64, 63);
            ty = clamp_tilt(tilt_y_m, -64, 63);
            push_le('h10, 1);
            push_le(flags, 1);
            push_le(scaled(x_m, 96012), 3);
            push_le(scaled(y_m, 54358), 3);
        end
        else
        begin
            pres = tip_m ? scaled(pres_m, 2047) : 0;
            tx = tilt_x_m;
            ty = tilt_y_m;
            push_le('h06, 1);
            push_le(flags, 1);
            push_le(scaled(x_m, 32767), 2);
            push_le(0, 1);
            push_le(scaled(y_m, 32767), 2);
            push_le(0, 1);
        end
        push_le(pres, 2);
        push_le(tx & 'hFF, 1);
        push_le(ty & 'hFF, 1);
        push_le(0, 4);
        push_le(dist_code, 1);
        push_le(in_range_m ? 'h97800A01 : 0, 4);
        push_le(in_range_m ? 'h00100842 : 0, 4);
        push_le(in_range_m ? (eraser_m ? 'h084A : 'h0842) : 0, 2);
        report_q[$].l = 1'b1;
    endfunction

    initial
    begin
        in_range_m = 0; tip_m = 0; eraser_m = 0; buttons_m = 0;
        x_m = 32768; y_m = 32768; pres_m = 0; dist_m = 65536;
        tilt_x_m = 0; tilt_y_m = 0;
    end

    always @(posedge clk)
    begin
        typed_head_t h;
        int base;
        if (rst_n)
        begin
            if (cfg_we) fmt_m = cfg_wdata;
            if (in_valid && in_ready)
            begin
                base = report_q.size();
                predict_report();
                if (typed_q.size() > 0)
                begin
                    h = typed_q[0];
                    typed_q.delete(0);
                    // directed rows pin the id and flags to hand-read values
                    if (h.typed)
                    begin
                        report_q[base].b = h.id_byte;
                        report_q[base + 1].b = h.flag_byte;
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report word 0x%02h with nothing expected", report_byte);
                    errors++;
                end
                else
                begin
                    report_word_t w;
                    w = report_q[0];
                    report_q.delete(0);
                    words_checked++;
                    if (report_byte !== w.b)
                    begin
                        $error("report_byte: expected 0x%02h, got 0x%02h", w.b, report_byte);
                        errors++;
                    end
                    if (last_byte !== w.l)
                    begin
                        $error("last_byte: expected %0d, got %0d", w.l, last_byte);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall pattern: rotate through four out_ready modes
    int rx_cycle = 0;
    always @(posedge clk)
    begin
        int mode;
        rx_cycle++;
        mode = (rx_cycle / 64) % 4;
        case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_event(input pen_row_t r);
        typed_head_t h;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        h.typed = r.typed;
        h.id_byte = r.id_byte;
        h.flag_byte = r.flag_byte;
        typed_q.insert(typed_q.size(), h);
        in_valid <= 1'b1;
        event_kind <= r.kind;
        tool_kind <= r.tool;
        button_bits <= r.buttons;
        pos_x <= r.x;
        pos_y <= r.y;
        pressure_or_distance <= r.pod;
        tilt_deg <= r.tilt;
        tilt_unknown <= r.tilt_unk;
        rotation_deg <= r.rot;
        rotation_unknown <= r.rot_unk;
        do @(posedge clk); while (!in_ready);
        events_sent++;
    endtask

    // drain, settle, then load a new report format
    task automatic set_format(input logic [1:0] v);
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (report_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic pen_row_t random_row(input logic [2:0] kind, input bit wild);
        pen_row_t r;
        r.fmt = fmt_m;
        r.kind = kind;
        r.typed = 0;
        r.id_byte = 0;
        r.flag_byte = 0;
        r.tool = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
        r.buttons = 8'($urandom_range(0, 255));
        if (wild)
        begin
            r.x = 18'($urandom);
            r.y = 18'($urandom);
            r.pod = 17'($urandom);
            r.tilt = 7'($urandom);
            r.rot = 9'($urandom);
        end
        else
        begin
            r.x = 18'($urandom_range(0, 65536));
            r.y = 18'($urandom_range(0, 65536));
            r.pod = ($urandom_range(0, 5) == 0) ? 17'd0 : 17'($urandom_range(1, 65536));
            r.tilt = 7'($urandom_range(0, 90));
            r.rot = 9'($urandom_range(0, 359));
        end
        r.tilt_unk = ($urandom_range(0, 7) == 0);
        r.rot_unk = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    pen_row_t directed[] = '{
        // fmt kind tool btn x y pod tilt tu rot ru typed id flags
        '{2'd1, psre_pkg::EV_BUTTONS, 2'd0, 8'h03, 18'sd0, 18'sd0, 17'd0, 7'd0, 1'b0,
          9'd0, 1'b0, 1, 8'h06, 8'h00},
        '{2'd1, psre_pkg::EV_HOVER, psre_pkg::TOOL_PEN, 8'h00, 18'sh20000, 18'sd131071,
          17'd0, 7'd0, 1'b0, 9'd0, 1'b0, 1, 8'h06, 8'h20},
        '{2'd1, psre_pkg::EV_DOWN, 2'd0, 8'h03, 18'sd100, 18'sd200, 17'd0, 7'd90, 1'b0,
          9'd0, 1'b0, 1, 8'h06, 8'h27},
        '{2'd1, psre_pkg::EV_MOVE, 2'd0, 8'h00, 18'sd65535, 18'sd1, 17'd131071, 7'd45,
          1'b0, 9'd90, 1'b0, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_MOVE, 2'd0, 8'h01, 18'sd40000, 18'sd30000, 17'd0, 7'd20,
          1'b1, 9'd10, 1'b0, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_MOVE, 2'd0, 8'h02, 18'sd30000, 18'sd40000, 17'd500, 7'd30,
          1'b0, 9'd45, 1'b1, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_UP, 2'd0, 8'h00, 18'sd30000, 18'sd40000, 17'd0, 7'd0, 1'b1,
          9'd0, 1'b1, 1, 8'h06, 8'h20},
        '{2'd1, psre_pkg::EV_HOVER, psre_pkg::TOOL_ERASER, 8'h00, 18'sd1, 18'sd1,
          17'd65536, 7'd10, 1'b0, 9'd359, 1'b0, 1, 8'h06, 8'h30},
        '{2'd1, psre_pkg::EV_DOWN, 2'd0, 8'h01, 18'sd2, 18'sd2, 17'd65536, 7'd60, 1'b0,
          9'd135, 1'b0, 1, 8'h06, 8'h3A},
        '{2'd1, psre_pkg::EV_CANCEL, 2'd0, 8'hFF, 18'sd5, 18'sd5, 17'd5, 7'd5, 1'b0,
          9'd5, 1'b0, 1, 8'h06, 8'h00},
        '{2'd1, psre_pkg::EV_HOVER, 2'd3, 8'hFC, 18'sd65536, 18'sd65537, 17'd1, 7'd127,
          1'b0, 9'd511, 1'b0, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_DOWN, 2'd0, 8'h00, 18'sd7, 18'sd9, 17'd1, 7'd60, 1'b0,
          9'd180, 1'b0, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_LEAVE, 2'd0, 8'h00, 18'sd0, 18'sd0, 17'd0, 7'd0, 1'b0,
          9'd0, 1'b0, 1, 8'h06, 8'h00},
        '{2'd1, psre_pkg::EV_HOVER, psre_pkg::TOOL_PEN, 8'hAA, 18'sd20000, 18'sd50000,
          17'd70000, 7'd90, 1'b0, 9'd270, 1'b0, 0, 8'h00, 8'h00},
        '{2'd1, psre_pkg::EV_CANCEL_ALL, 2'd0, 8'h55, 18'sd0, 18'sd0, 17'd0, 7'd0, 1'b0,
          9'd0, 1'b0, 1, 8'h06, 8'h00},
        '{2'd2, psre_pkg::EV_HOVER, psre_pkg::TOOL_PEN, 8'h00, 18'sd0, 18'sd0, 17'd0,
          7'd0, 1'b0, 9'd0, 1'b0, 1, 8'h10, 8'h60},
        '{2'd2, psre_pkg::EV_DOWN, 2'd0, 8'h02, 18'sd65536, 18'sd65536, 17'd65536,
          7'd90, 1'b0, 9'd90, 1'b0, 1, 8'h10, 8'h65},
        '{2'd2, psre_pkg::EV_MOVE, 2'd0, 8'h00, 18'sd131071, -18'sd1, 17'd0, 7'd90,
          1'b0, 9'd270, 1'b0, 0, 8'h00, 8'h00},
        '{2'd2, psre_pkg::EV_UP, 2'd0, 8'h00, 18'sd3, 18'sd3, 17'd0, 7'd80, 1'b0,
          9'd225, 1'b0, 0, 8'h00, 8'h00},
        '{2'd2, psre_pkg::EV_LEAVE, 2'd0, 8'h00, 18'sd0, 18'sd0, 17'd0, 7'd0, 1'b0,
          9'd0, 1'b0, 1, 8'h10, 8'h40},
        '{2'd0, psre_pkg::EV_HOVER, psre_pkg::TOOL_PEN, 8'h00, 18'sd9, 18'sd9, 17'd9,
          7'd9, 1'b0, 9'd9, 1'b0, 1, 8'h06, 8'h20},
        '{2'd3, psre_pkg::EV_DOWN, 2'd0, 8'h00, 18'sd9, 18'sd9, 17'd9, 7'd9, 1'b0,
          9'd9, 1'b0, 1, 8'h06, 8'h21}
    };

    initial
    begin
        logic [1:0] formats[6];
        int strokes;
        pen_row_t r;
        formats = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].fmt != fmt_m) set_format(directed[i].fmt);
            send_event(directed[i]);
        end

        for (int p = 0; p < 6; p++)
        begin
            set_format(formats[p]);
            strokes = 0;
            while (strokes < 24)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // noise: any kind, any field value
                    send_event(random_row(3'($urandom_range(0, 7)), 1'b1));
                    strokes++;
                end
                else
                begin
                    // hover in, touch, drag, maybe buttons, lift, hover, leave or cancel
                    send_event(random_row(psre_pkg::EV_HOVER, 1'b0));
                    send_event(random_row(psre_pkg::EV_DOWN, 1'b0));
                    repeat ($urandom_range(1, 4))
                        send_event(random_row(psre_pkg::EV_MOVE, 1'b0));
                    if ($urandom_range(0, 1) == 1)
                        send_event(random_row(psre_pkg::EV_BUTTONS, 1'b0));
                    send_event(random_row(psre_pkg::EV_UP, 1'b0));
                    send_event(random_row(psre_pkg::EV_MOVE, 1'b0));
                    send_event(random_row($urandom_range(0, 2) == 0 ? psre_pkg::EV_CANCEL :
                                          psre_pkg::EV_LEAVE, 1'b0));
                    strokes += 6;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d pen events over all four format codes, %0d report words checked",
                 events_sent, words_checked);
        $display("strokes, tool swaps, cancels and unknown tilt/rotation were exercised");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* sim.f */
design/psre_pkg.sv
design/psre_front.sv
design/psre_back.sv
design/pen_state_report_encoder_unit.sv
bench/testbench.sv
